FILE: hw/rtl/intersection_pollutant_balance_unit_assert.svh
// Assertion macros for the intersection pollutant balance unit.
// Expects clk_i and rst_ni in the scope of the module that includes it.
`ifndef INTERSECTION_POLLUTANT_BALANCE_UNIT_ASSERT_SVH
`define INTERSECTION_POLLUTANT_BALANCE_UNIT_ASSERT_SVH

// Same-cycle implication
`define IPB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ipb_pkg.sv
// Shared constants, types and saturating helpers of the pollutant balance unit.
// No dependencies.
package ipb_pkg;

  localparam int MAX_STREETS_DEF  = 8;
  localparam int STREET_COUNT_DEF = 1024;

  localparam int QW     = 48;
  localparam int CONC_W = 31;
  localparam int FLUX_W = 32;
  localparam int SIDX_W = 10;
  localparam int ACT_W  = 3;
  localparam int SLOT_W = 4;
  localparam int CAT_W  = 2;
  localparam int CNT_W  = 4;
  localparam int MUL_W  = 32;

  localparam logic [CONC_W-1:0] MIN_FLUX_RST = 31'd655360;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SLOT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FLUX   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FINISH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  typedef logic signed [QW-1:0] q48_t;

  localparam q48_t SAT_HI = {1'b0, {(QW-1){1'b1}}};
  localparam q48_t SAT_LO = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] mul;
    q48_t             num;
    q48_t             den;
  } div_req_t;

  function automatic q48_t sat_add(q48_t a, q48_t b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? SAT_LO : SAT_HI;
    return s[QW-1:0];
  endfunction

  function automatic q48_t sat_sub(q48_t a, q48_t b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? SAT_LO : SAT_HI;
    return s[QW-1:0];
  endfunction

endpackage

FILE: hw/rtl/ipb_divider.sv
// Multi-cycle unit: mul * num / den, truncated toward zero, saturated to 48 bits.
// Two partial products, then one quotient bit per cycle. Uses ipb_pkg.
module ipb_divider import ipb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output q48_t     quot_o
);

  localparam int NW = MUL_W + QW;
  localparam int KW = $clog2(QW);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_MLO  = 3'd1;
  localparam logic [2:0] D_MHI  = 3'd2;
  localparam logic [2:0] D_CHK  = 3'd3;
  localparam logic [2:0] D_LOOP = 3'd4;
  localparam logic [2:0] D_OUT  = 3'd5;

  logic [2:0]       st_q;
  logic [KW-1:0]    cnt_q;
  logic             done_q;
  logic [MUL_W-1:0] a_q;
  logic [QW-1:0]    av_q, ap_q, rem_q, quo_q;
  logic             neg_q, ovf_q;
  logic [NW-1:0]    n_q;
  q48_t             quot_q;

  logic [2*MUL_W-1:0] p_lo;
  logic [QW-1:0]      p_hi;
  logic [QW:0]        rem_sh;
  logic               take;
  logic               big;

  assign p_lo   = a_q * av_q[MUL_W-1:0];
  assign p_hi   = a_q * av_q[QW-1:MUL_W];
  assign rem_sh = {rem_q, n_q[QW-1]};
  assign take   = rem_sh >= {1'b0, ap_q};
  assign big    = ovf_q | quo_q[QW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        D_IDLE: begin
          if (req_i.start) st_q <= D_MLO;
        end
        D_MLO: st_q <= D_MHI;
        D_MHI: st_q <= D_CHK;
        D_CHK: begin
          st_q  <= D_LOOP;
          cnt_q <= KW'(QW - 1);
        end
        D_LOOP: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) st_q <= D_OUT;
        end
        D_OUT: begin
          st_q   <= D_IDLE;
          done_q <= 1'b1;
        end
        default: st_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      D_IDLE: begin
        a_q   <= req_i.mul;
        av_q  <= req_i.num[QW-1] ? (~req_i.num + 1'b1) : req_i.num;
        ap_q  <= req_i.den[QW-1] ? (~req_i.den + 1'b1) : req_i.den;
        neg_q <= req_i.num[QW-1] ^ req_i.den[QW-1];
      end
      D_MLO: n_q <= NW'(p_lo);
      D_MHI: n_q <= n_q + {p_hi, {MUL_W{1'b0}}};
      D_CHK: begin
        ovf_q <= QW'(n_q[NW-1:QW]) >= ap_q;
        rem_q <= QW'(n_q[NW-1:QW]);
        quo_q <= '0;
      end
      D_LOOP: begin
        rem_q <= take ? QW'(rem_sh - {1'b0, ap_q}) : rem_sh[QW-1:0];
        quo_q <= {quo_q[QW-2:0], take};
        n_q   <= n_q << 1;
      end
      D_OUT: begin
        if (neg_q) quot_q <= big ? SAT_LO : q48_t'(~quo_q + 1'b1);
        else       quot_q <= big ? SAT_HI : q48_t'(quo_q);
      end
      default: ;
    endcase
  end

  assign busy_o = st_q != D_IDLE;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: hw/rtl/ipb_accum_mem.sv
// Per-street 48-bit accumulator store with a clearing sweep after reset
// and on request. Uses ipb_pkg.
module ipb_accum_mem import ipb_pkg::*; #(
  parameter int DEPTH = STREET_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  output logic          busy_o,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output q48_t          rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  q48_t          wr_data_i
);

  logic          clr_q;
  logic [AW-1:0] ptr_q;
  q48_t          mem_q [DEPTH];
  q48_t          rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      ptr_q <= '0;
    end else if (clr_i) begin
      clr_q <= 1'b1;
      ptr_q <= '0;
    end else if (clr_q) begin
      ptr_q <= ptr_q + 1'b1;
      if (ptr_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q)        mem_q[ptr_q]     <= '0;
    else if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_q <= mem_q[rd_addr_i];
  end

  assign busy_o    = clr_q;
  assign rd_data_o = rd_q;

endmodule

FILE: hw/rtl/intersection_pollutant_balance_unit.sv
// Top level of the intersection pollutant balance unit: sequencer, slot and
// flux stores, shared divider. Uses ipb_pkg, ipb_divider, ipb_accum_mem.
//
//   channel  direction  handshake                    payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  tdata fields, tuser action
//   m_axis   out        m_axis_tvalid/m_axis_tready  tdata results, tuser computed
//   cfg      in         cfg_valid_i/cfg_ready_o      min_total_flux
//
// A read fetches the accumulator, a finish of another category emits directly. A balance
// over n streets runs horizontal and vertical passes; with nonzero total flux it divides
// for n(n+1)+1 source shares and, above min_total_flux, the node concentration. After
// reset and after each clear item the accumulator sweep clears all STREET_COUNT entries,
// with s_axis_tready low. A result waits in the output register; loads are still taken,
// but the next finish or read stalls at its end until that result is accepted.
`include "intersection_pollutant_balance_unit_assert.svh"
module intersection_pollutant_balance_unit import ipb_pkg::*; #(
  parameter int MAX_STREETS_PER_NODE = MAX_STREETS_DEF,
  parameter int STREET_COUNT         = STREET_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot, column, street_index, street_conc, flux_value, node_ext_conc,
  // node_source, node_category, street_count
  input  logic [151:0] s_axis_tdata,
  // action
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // node_conc, vert_in_flux, vert_out_flux, vert_net_flux, vert_in_rate,
  // vert_out_rate, street_flux
  output logic [335:0] m_axis_tdata,
  // node_computed
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i
);

  localparam int MDIM   = MAX_STREETS_PER_NODE + 1;
  localparam int FDEPTH = MDIM * MDIM;
  localparam int FAW    = $clog2(FDEPTH);
  localparam int SAW    = $clog2(MAX_STREETS_PER_NODE);
  localparam int CW     = $clog2(MAX_STREETS_PER_NODE + 2);
  localparam int AW     = $clog2(STREET_COUNT);
  localparam int SW     = SIDX_W + CONC_W;
  localparam logic [MUL_W-1:0] ONE_Q = 32'h0001_0000;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RD_ISS = 5'd1;
  localparam logic [4:0] S_RD_LAT = 5'd2;
  localparam logic [4:0] S_ROW    = 5'd3;
  localparam logic [4:0] S_ROW_SL = 5'd4;
  localparam logic [4:0] S_ROW_AC = 5'd5;
  localparam logic [4:0] S_T_RD   = 5'd6;
  localparam logic [4:0] S_T_MUL  = 5'd7;
  localparam logic [4:0] S_T_ACC  = 5'd8;
  localparam logic [4:0] S_T_DIV  = 5'd9;
  localparam logic [4:0] S_T_DW   = 5'd10;
  localparam logic [4:0] S_ROW_WR = 5'd11;
  localparam logic [4:0] S_QO     = 5'd12;
  localparam logic [4:0] S_QO_W   = 5'd13;
  localparam logic [4:0] S_QT     = 5'd14;
  localparam logic [4:0] S_NC     = 5'd15;
  localparam logic [4:0] S_NC_W   = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  localparam logic [1:0] PH_HOR  = 2'd0;
  localparam logic [1:0] PH_VERT = 2'd1;
  localparam logic [1:0] PH_SRC  = 2'd2;

  // input fields
  logic [ACT_W-1:0]         in_action;
  logic [SLOT_W-1:0]        in_slot, in_column;
  logic [SIDX_W-1:0]        in_sidx;
  logic [CONC_W-1:0]        in_sconc, in_cext, in_qsrc;
  logic signed [FLUX_W-1:0] in_flux;
  logic [CAT_W-1:0]         in_categ;
  logic [CNT_W-1:0]         in_count;
  logic                     in_acc;

  assign in_action = s_axis_tuser;
  assign in_slot   = s_axis_tdata[3:0];
  assign in_column = s_axis_tdata[7:4];
  assign in_sidx   = s_axis_tdata[17:8];
  assign in_sconc  = s_axis_tdata[48:18];
  assign in_flux   = s_axis_tdata[80:49];
  assign in_cext   = s_axis_tdata[111:81];
  assign in_qsrc   = s_axis_tdata[142:112];
  assign in_categ  = s_axis_tdata[144:143];
  assign in_count  = s_axis_tdata[148:145];

  // control
  logic [4:0]        state_q;
  logic [1:0]        ph_q;
  logic [CW-1:0]     is_q, ie_q, n_q;
  logic              m_valid_q;
  logic [CONC_W-1:0] min_q;

  // datapath
  logic [SIDX_W-1:0]        sidx_q, street_q;
  logic [CONC_W-1:0]        cext_q, qsrc_q, conc_is_q;
  logic signed [FLUX_W-1:0] flux_q;
  logic signed [63:0]       prod_q;
  q48_t acc_q, qin_q, qout_q, pin_q, pout_q, qtot_q, ptot_q, nconc_q, sflux_q;
  logic computed_q;
  q48_t o_nconc_q, o_qin_q, o_qout_q, o_net_q, o_pin_q, o_pout_q, o_sflux_q;
  logic o_comp_q;

  // stores
  logic [SW-1:0]            slot_mem_q [MAX_STREETS_PER_NODE];
  logic signed [FLUX_W-1:0] flux_mem_q [FDEPTH];
  logic [SW-1:0]            slot_rd_q;
  logic signed [FLUX_W-1:0] flux_rd_q;
  logic                     slot_rd_en, flux_rd_en;
  logic [SAW-1:0]           slot_rd_addr;
  logic [FAW-1:0]           flux_rd_addr;
  logic [CW-1:0]            fr, fc;

  logic          acc_clr, acc_busy, acc_rd_en, acc_wr_en;
  logic [AW-1:0] acc_rd_addr;
  logic [SIDX_W-1:0] acc_rd_street;
  q48_t          acc_rd_data;

  div_req_t div_req;
  logic     div_busy, div_done;
  q48_t     div_q;

  logic [CW-1:0]     n_in;
  logic              t_end;
  logic [CONC_W-1:0] conc_sel;
  q48_t              t48, fx48, fxrd48;
  logic [QW-1:0]     ptot_abs;
  logic              big_flux;
  logic              street_ok, sidx_ok;

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) & ~acc_busy;
  assign cfg_ready_o   = 1'b1;

  assign n_in = (32'(in_count) > MAX_STREETS_PER_NODE) ?
                CW'(MAX_STREETS_PER_NODE) : CW'(in_count);

  assign t_end = ((ph_q == PH_HOR)  && (ie_q == n_q)) ||
                 ((ph_q == PH_VERT) && (ie_q == CW'(2))) ||
                 ((ph_q == PH_SRC)  && (ie_q == n_q + 1'b1));

  // flux entry of the current term
  always_comb begin
    fr = ie_q;
    fc = is_q;
    if (ph_q == PH_VERT) begin
      if (ie_q == '0) begin
        fr = n_q;
        fc = is_q;
      end else begin
        fr = is_q;
        fc = n_q;
      end
    end
  end

  assign flux_rd_en   = state_q == S_T_RD;
  assign flux_rd_addr = FAW'(32'(fr) * MDIM + 32'(fc));
  assign slot_rd_en   = (state_q == S_ROW) | (state_q == S_T_RD);
  assign slot_rd_addr = (state_q == S_ROW) ? is_q[SAW-1:0] : ie_q[SAW-1:0];

  assign conc_sel = (ph_q == PH_HOR) ? slot_rd_q[CONC_W-1:0] :
                    (ie_q == '0) ? cext_q : conc_is_q;
  assign t48      = prod_q[QW+15:16];
  assign fx48     = {{(QW-FLUX_W){flux_q[FLUX_W-1]}}, flux_q};
  assign fxrd48   = {{(QW-FLUX_W){flux_rd_q[FLUX_W-1]}}, flux_rd_q};
  assign ptot_abs = ptot_q[QW-1] ? (~ptot_q + 1'b1) : ptot_q;
  assign big_flux = ptot_abs > QW'(min_q);

  assign street_ok = 32'(street_q) < STREET_COUNT;
  assign sidx_ok   = 32'(sidx_q) < STREET_COUNT;

  assign acc_clr       = in_acc & (in_action == ACT_CLEAR);
  assign acc_rd_en     = (state_q == S_ROW_SL) | (state_q == S_RD_ISS);
  assign acc_rd_street = (state_q == S_ROW_SL) ? slot_rd_q[SW-1:CONC_W] : sidx_q;
  assign acc_rd_addr   = AW'(acc_rd_street);
  assign acc_wr_en     = (state_q == S_ROW_WR) & street_ok;

  always_comb begin
    div_req.start = 1'b0;
    div_req.mul   = MUL_W'(qsrc_q);
    div_req.num   = fxrd48;
    div_req.den   = ptot_q;
    case (state_q)
      S_T_DIV: div_req.start = 1'b1;
      S_QO: begin
        div_req.start = 1'b1;
        div_req.num   = pout_q;
      end
      S_NC: begin
        div_req.start = big_flux;
        div_req.mul   = ONE_Q;
        div_req.num   = qtot_q;
      end
      default: ;
    endcase
  end

  ipb_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_q)
  );

  ipb_accum_mem #(
    .DEPTH (STREET_COUNT),
    .AW    (AW)
  ) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (acc_clr),
    .busy_o    (acc_busy),
    .rd_en_i   (acc_rd_en),
    .rd_addr_i (acc_rd_addr),
    .rd_data_o (acc_rd_data),
    .wr_en_i   (acc_wr_en),
    .wr_addr_i (AW'(street_q)),
    .wr_data_i (acc_q)
  );

  // slot and flux stores
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_action == ACT_SLOT) && (32'(in_slot) < MAX_STREETS_PER_NODE))
      slot_mem_q[SAW'(in_slot)] <= {in_sidx, in_sconc};
    if (in_acc && (in_action == ACT_FLUX) && (32'(in_slot) < MDIM) &&
        (32'(in_column) < MDIM))
      flux_mem_q[FAW'(32'(in_slot) * MDIM + 32'(in_column))] <= in_flux;
    if (slot_rd_en) slot_rd_q <= slot_mem_q[slot_rd_addr];
    if (flux_rd_en) flux_rd_q <= flux_mem_q[flux_rd_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ph_q      <= PH_HOR;
      is_q      <= '0;
      ie_q      <= '0;
      n_q       <= '0;
      m_valid_q <= 1'b0;
      min_q     <= MIN_FLUX_RST;
    end else begin
      if (cfg_valid_i) min_q <= cfg_data_i;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_action)
              ACT_FINISH: begin
                n_q  <= n_in;
                ph_q <= PH_HOR;
                is_q <= '0;
                state_q <= (in_categ == '0) ? S_ROW : S_EMIT;
              end
              ACT_READ: state_q <= S_RD_ISS;
              default: ;
            endcase
          end
        end
        S_RD_ISS: state_q <= S_RD_LAT;
        S_RD_LAT: state_q <= S_EMIT;
        S_ROW: begin
          if (is_q == n_q) begin
            is_q <= '0;
            case (ph_q)
              PH_HOR: ph_q <= PH_VERT;
              PH_VERT: begin
                if (ptot_q != '0) ph_q <= PH_SRC;
                else              state_q <= S_QT;
              end
              default: state_q <= S_QO;
            endcase
          end else begin
            state_q <= S_ROW_SL;
          end
        end
        S_ROW_SL: state_q <= S_ROW_AC;
        S_ROW_AC: begin
          ie_q    <= '0;
          state_q <= S_T_RD;
        end
        S_T_RD: begin
          if (t_end)                 state_q <= S_ROW_WR;
          else if (ph_q == PH_SRC)   state_q <= S_T_DIV;
          else                       state_q <= S_T_MUL;
        end
        S_T_MUL: state_q <= S_T_ACC;
        S_T_ACC: begin
          ie_q    <= ie_q + 1'b1;
          state_q <= S_T_RD;
        end
        S_T_DIV: state_q <= S_T_DW;
        S_T_DW: begin
          if (div_done) begin
            ie_q    <= ie_q + 1'b1;
            state_q <= S_T_RD;
          end
        end
        S_ROW_WR: begin
          is_q    <= is_q + 1'b1;
          state_q <= S_ROW;
        end
        S_QO: state_q <= S_QO_W;
        S_QO_W: begin
          if (div_done) state_q <= S_QT;
        end
        S_QT: state_q <= S_NC;
        S_NC: state_q <= big_flux ? S_NC_W : S_EMIT;
        S_NC_W: begin
          if (div_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_valid_q) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        sidx_q     <= in_sidx;
        cext_q     <= in_cext;
        qsrc_q     <= in_qsrc;
        qin_q      <= '0;
        qout_q     <= '0;
        pin_q      <= '0;
        pout_q     <= '0;
        qtot_q     <= '0;
        ptot_q     <= '0;
        nconc_q    <= '0;
        sflux_q    <= '0;
        computed_q <= (in_action == ACT_FINISH) && (in_categ == '0);
      end
      S_RD_LAT: sflux_q <= sidx_ok ? acc_rd_data : '0;
      S_ROW_SL: begin
        street_q  <= slot_rd_q[SW-1:CONC_W];
        conc_is_q <= slot_rd_q[CONC_W-1:0];
      end
      S_ROW_AC: acc_q <= acc_rd_data;
      S_T_MUL: begin
        prod_q <= $signed({1'b0, conc_sel}) * flux_rd_q;
        flux_q <= flux_rd_q;
      end
      S_T_ACC: begin
        qtot_q <= sat_add(qtot_q, t48);
        ptot_q <= sat_add(ptot_q, fx48);
        if (ph_q == PH_HOR) begin
          acc_q <= sat_add(acc_q, t48);
        end else if (ie_q == '0) begin
          acc_q <= sat_add(acc_q, t48);
          qin_q <= sat_add(qin_q, t48);
          pin_q <= sat_add(pin_q, fx48);
        end else begin
          qout_q <= sat_add(qout_q, t48);
          pout_q <= sat_add(pout_q, fx48);
        end
      end
      S_T_DW: begin
        if (div_done) acc_q <= sat_add(acc_q, div_q);
      end
      S_QO_W: begin
        if (div_done) qout_q <= sat_add(qout_q, div_q);
      end
      S_QT: qtot_q <= sat_add(qtot_q, q48_t'({{(QW-CONC_W){1'b0}}, qsrc_q}));
      S_NC: begin
        if (!big_flux) nconc_q <= q48_t'({{(QW-CONC_W){1'b0}}, cext_q});
      end
      S_NC_W: begin
        if (div_done) nconc_q <= div_q;
      end
      S_EMIT: begin
        if (!m_valid_q) begin
          o_nconc_q <= nconc_q;
          o_qin_q   <= qin_q;
          o_qout_q  <= qout_q;
          o_net_q   <= sat_sub(qout_q, qin_q);
          o_pin_q   <= pin_q;
          o_pout_q  <= pout_q;
          o_sflux_q <= sflux_q;
          o_comp_q  <= computed_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_sflux_q, o_pout_q, o_pin_q, o_net_q, o_qout_q, o_qin_q, o_nconc_q};
  assign m_axis_tuser  = o_comp_q;

  `IPB_ASSERT_SAME(a_div_start_free, div_req.start, !div_busy, "divider started while busy")
  `IPB_ASSERT_SAME(a_acc_wr_not_clr, acc_wr_en, !acc_busy, "accumulator write during sweep")
  `IPB_ASSERT_NEXT(a_finish_leaves_idle, in_acc && (in_action == ACT_FINISH), state_q != S_IDLE,
                   "finish item did not start the sequence")

endmodule
